@@ design/call_id_bucket_hash_macros.svh @@
// ---------------------------------------------------------------------------
// Call-ID bucket hash: assertion macros
// Shared assertion forms for the bucket hash modules.
// ---------------------------------------------------------------------------
`ifndef CALL_ID_BUCKET_HASH_MACROS_SVH
`define CALL_ID_BUCKET_HASH_MACROS_SVH

// Checked on every clock edge outside reset.
`define CIDH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CIDH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/cidh_pkg.sv @@
// ---------------------------------------------------------------------------
// Call-ID bucket hash: package
// Widths, reset values, controller commands and datapath helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package cidh_pkg;

  localparam int DATA_W   = 8;
  localparam int TS_W     = 17;
  localparam int IDX_W    = 16;
  localparam int HASH_W   = 32;
  localparam int POS_W    = 2;
  localparam int STEP_W   = $clog2(HASH_W);

  localparam logic [TS_W-1:0]   TABLE_SIZE_RESET = TS_W'(256);
  localparam logic [TS_W-1:0]   DIVISOR_MAX      = TS_W'(65536);
  localparam logic [STEP_W-1:0] STEP_LAST        = STEP_W'(HASH_W - 1);

  typedef struct packed {
    logic take_byte;
    logic tail_mix;
    logic final_mix;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic [HASH_W-1:0] word_mix(input logic [HASH_W-1:0] w);
    return w ^ (w >> 3);
  endfunction

  function automatic logic [HASH_W-1:0] final_mix(input logic [HASH_W-1:0] h);
    return (h + (h >> 11)) + ((h >> 13) + (h >> 23));
  endfunction

  function automatic logic [TS_W-1:0] clamp_divisor(input logic [TS_W-1:0] ts);
    logic [TS_W-1:0] d;
    d = ts;
    if (ts == '0) begin
      d = TS_W'(1);
    end else if (ts > DIVISOR_MAX) begin
      d = DIVISOR_MAX;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/cidh_datapath.sv @@
// ---------------------------------------------------------------------------
// Call-ID bucket hash: datapath
// Byte packing, word sum, final mix, bit-serial remainder and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "call_id_bucket_hash_macros.svh"

module cidh_datapath import cidh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic [DATA_W-1:0] data_byte,
  input  wire logic              cfg_write,
  input  wire logic [TS_W-1:0]   cfg_data,
  output logic [IDX_W-1:0]       bucket_index
);

  logic [TS_W-1:0]   table_size;
  logic [HASH_W-1:0] running_sum;
  logic [HASH_W-1:0] partial_word;
  logic [POS_W-1:0]  byte_position;
  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] dividend;
  logic [TS_W-1:0]   divisor;
  logic [TS_W-1:0]   remainder;
  logic [STEP_W-1:0] step;

  logic [HASH_W-1:0] partial_next;
  logic [POS_W-1:0]  position_next;
  logic [TS_W:0]     trial;
  logic [TS_W-1:0]   remainder_next;

  assign partial_next  = {partial_word[HASH_W-DATA_W-1:0], data_byte};
  assign position_next = byte_position + POS_W'(1);
  assign trial         = {remainder, dividend[HASH_W-1]};
  assign status.div_done = (step == STEP_LAST);

  always_comb begin
    remainder_next = trial[TS_W-1:0];
    if (trial >= {1'b0, divisor}) begin
      remainder_next = TS_W'(trial - {1'b0, divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size    <= TABLE_SIZE_RESET;
      running_sum   <= '0;
      partial_word  <= '0;
      byte_position <= '0;
      divisor       <= TS_W'(1);
      remainder     <= '0;
      step          <= '0;
    end else begin
      if (cfg_write) begin
        table_size <= cfg_data;
      end
      if (cmd.take_byte) begin
        byte_position <= position_next;
        if (position_next == '0) begin
          running_sum  <= running_sum + word_mix(partial_next);
          partial_word <= '0;
        end else begin
          partial_word <= partial_next;
        end
      end
      if (cmd.tail_mix) begin
        running_sum   <= '0;
        partial_word  <= '0;
        byte_position <= '0;
      end
      if (cmd.final_mix) begin
        divisor   <= clamp_divisor(table_size);
        remainder <= '0;
        step      <= '0;
      end
      if (cmd.div_step) begin
        remainder <= remainder_next;
        step      <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tail_mix) begin
      hash <= running_sum + word_mix(partial_word);
    end
    if (cmd.final_mix) begin
      dividend <= final_mix(hash);
    end else if (cmd.div_step) begin
      dividend <= {dividend[HASH_W-2:0], 1'b0};
    end
    if (cmd.load_out) begin
      bucket_index <= remainder[IDX_W-1:0];
    end
  end

  `CIDH_ASSERT(a_rem_below_divisor, remainder < divisor, "Remainder reached the divisor.")
  `CIDH_ASSERT(a_tail_clears, cmd.tail_mix |=> byte_position == '0 && partial_word == '0,
    "String state not cleared after the tail word.")
  `CIDH_ASSERT(a_step_clear, cmd.final_mix |=> step == '0 && remainder == '0,
    "Remainder unit not cleared at division start.")

endmodule

`default_nettype wire

@@ design/cidh_ctrl.sv @@
// ---------------------------------------------------------------------------
// Call-ID bucket hash: controller
// Sequences byte intake, tail and final mix, the division and the result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "call_id_bucket_hash_macros.svh"

module cidh_ctrl import cidh_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    last_byte,
  output logic         in_stall,
  input  wire logic    out_stall,
  output logic         out_valid,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAIL,
    S_FINAL,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.take_byte = accept;
    cmd.tail_mix  = (state == S_TAIL);
    cmd.final_mix = (state == S_FINAL);
    cmd.div_step  = (state == S_DIV);
    cmd.load_out  = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !cmd.load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && last_byte) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_FINAL;
        end
        S_FINAL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CIDH_ASSERT(a_last_starts_tail, accept && last_byte |=> state == S_TAIL,
    "Last byte did not start the tail mix.")
  `CIDH_ASSERT(a_div_ends, state == S_DIV && status.div_done |=> state == S_OUT,
    "Division did not end after its last step.")
  `CIDH_ASSERT(a_load_free, cmd.load_out |=> out_valid,
    "Result load did not raise the output valid.")
  `CIDH_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE && !out_valid,
    "Reset did not return the controller to idle.")

endmodule

`default_nettype wire

@@ design/call_id_bucket_hash.sv @@
// ---------------------------------------------------------------------------
// Call-ID bucket hash
// Hashes a byte string into a bucket index modulo the configured table size (clamped to 1..65536).
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     data_byte, last_byte
//   out      output     out_valid / out_stall   bucket_index
//   cfg      input      cfg_valid / cfg_ready   table_size
//
// Bytes before the last one are taken at one per cycle.
// After the last byte the block stalls its input through the tail mix, the
// final mix, the one-bit-per-cycle remainder unit and the result load.
// The result register holds a finished index while the next string streams in.
// A stalled output holds back the result load of the following string and keeps the input stalled until that load.
// Reset is synchronous; it sets the table size to 256 and clears the string.
// ---------------------------------------------------------------------------
`default_nettype none

module call_id_bucket_hash import cidh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] data_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [IDX_W-1:0]       bucket_index,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TS_W-1:0]   table_size
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  cidh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_byte (last_byte),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  cidh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .data_byte    (data_byte),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (table_size),
    .bucket_index (bucket_index)
  );

endmodule

`default_nettype wire
